/* rtl/trma_pkg.sv */
// Shared types and codes for the token ring membership arbiter.
// No dependencies; compiled first.
`default_nettype none

package trma_pkg;

  localparam int CMD_W = 2;
  localparam int ID_W  = 16;
  localparam int IDX_W = 6;
  localparam int ST_W  = 2;
  localparam int CNT_W = 7;

  typedef logic [CMD_W-1:0] cmd_t;
  typedef logic [ID_W-1:0]  id_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [ST_W-1:0]  status_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // command codes
  localparam cmd_t CMD_JOIN    = 2'd0;
  localparam cmd_t CMD_LEAVE   = 2'd1;
  localparam cmd_t CMD_SERVICE = 2'd2;
  localparam cmd_t CMD_READ    = 2'd3;

  // status codes
  localparam status_t ST_DONE       = 2'd0;
  localparam status_t ST_JOIN_BUSY  = 2'd1;
  localparam status_t ST_NOT_HOLDER = 2'd2;
  localparam status_t ST_BAD_ID     = 2'd3;

endpackage

`default_nettype wire

/* rtl/trma_if.sv */
// Valid/ready channel interfaces for request and response transfers.
// Depends on trma_pkg.
`default_nettype none

interface trma_req_if;
  logic              valid;
  logic              ready;
  trma_pkg::cmd_t    command;
  trma_pkg::id_t     member_id;
  trma_pkg::idx_t    slot_index;

  modport source (output valid, command, member_id, slot_index, input ready);
  modport sink   (input valid, command, member_id, slot_index, output ready);
endinterface

interface trma_rsp_if;
  logic              valid;
  logic              ready;
  trma_pkg::status_t status;
  trma_pkg::id_t     holder_id;
  trma_pkg::cnt_t    count_now;
  logic              list_changed;
  trma_pkg::id_t     slot_value;
  logic              table_emptied;

  modport source (output valid, status, holder_id, count_now, list_changed, slot_value,
                  table_emptied, input ready);
  modport sink   (input valid, status, holder_id, count_now, list_changed, slot_value,
                  table_emptied, output ready);
endinterface

`default_nettype wire

/* rtl/token_ring_membership_arbiter_unit.sv */
// Token ring membership arbiter: member table, parked join/leave, token passing.
// Depends on trma_pkg and the channel interfaces in trma_if.sv.
//
//   channel   | direction | payload                                         | transfer
//   ----------+-----------+-------------------------------------------------+-----------------
//   in_req    | sink      | command, member_id, slot_index                  | valid & ready
//   out_rsp   | source    | status, holder_id, count_now, list_changed,     | valid & ready
//             |           | slot_value, table_emptied                       |
//
// Join and rejected requests go straight to the response load; a read first reads its slot.
// Leave and service scan the table to pass the token; an applied parked leave also scans and
// compacts it (rereading slot 0 for a tail holder). Searches and compaction walk the table one
// slot per cycle through its single read port. One request is in flight at a time;
// in_req.ready is high only while idle. A finished response sits in the output register, so
// the next request is taken while it waits; a new response waits for out_rsp.ready.
// Synchronous active-low reset empties the table through per-slot valid bits (no sweep).
`default_nettype none

module token_ring_membership_arbiter_unit #(
  parameter int SLOTS = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  trma_req_if.sink     in_req,
  trma_rsp_if.source   out_rsp
);

  localparam int AW = $clog2(SLOTS);       // slot address
  localparam int CW = $clog2(SLOTS + 1);   // member count
  localparam int PW = $clog2(SLOTS + 2);   // walk pointer, runs one past the count
  localparam int OW = trma_pkg::CNT_W;
  localparam int IW = trma_pkg::IDX_W + 1;

  localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);
  localparam logic [PW-1:0] SLOTS_P = PW'(SLOTS);

  // sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_RDW      = 4'd1;   // wait for slot read
  localparam logic [3:0] S_DISP     = 4'd2;   // pick next step of leave/service
  localparam logic [3:0] S_LV_SCAN  = 4'd3;   // find parked leave
  localparam logic [3:0] S_LV_SHIFT = 4'd4;   // compact entries down
  localparam logic [3:0] S_LV_HEAD  = 4'd5;   // read slot 0 for new holder
  localparam logic [3:0] S_LV_OWN   = 4'd6;
  localparam logic [3:0] S_PS_SCAN  = 4'd7;   // find last slot of requester
  localparam logic [3:0] S_PS_RD    = 4'd8;   // read successor
  localparam logic [3:0] S_PS_GET   = 4'd9;
  localparam logic [3:0] S_FIN      = 4'd10;  // load response register

  // leave/service step
  localparam logic [1:0] PH_PRE  = 2'd0;
  localparam logic [1:0] PH_PARK = 2'd1;
  localparam logic [1:0] PH_LAST = 2'd2;
  localparam logic [1:0] PH_PASS = 2'd3;

  // member table: one write, one registered read per cycle
  logic [trma_pkg::ID_W-1:0] mem_r [SLOTS];
  logic [SLOTS-1:0]          vld_r;
  logic [trma_pkg::ID_W-1:0] rd_data_r;
  logic                      rd_vld_r;
  trma_pkg::id_t             slot_q;

  logic [AW-1:0]             rd_addr;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  trma_pkg::id_t             wr_data;

  // control state
  logic [3:0]        state_r,  state_nxt;
  logic [1:0]        phase_r,  phase_nxt;
  logic [CW-1:0]     count_r,  count_nxt;
  trma_pkg::id_t     owner_r,  owner_nxt;
  trma_pkg::id_t     pj_r,     pj_nxt;
  trma_pkg::id_t     pl_r,     pl_nxt;
  logic              out_valid_r, out_valid_nxt;

  // working registers
  trma_pkg::cmd_t    cmd_r,     cmd_nxt;
  trma_pkg::id_t     id_r,      id_nxt;
  trma_pkg::status_t status_r,  status_nxt;
  logic              changed_r, changed_nxt;
  trma_pkg::id_t     slot_r,    slot_nxt;
  logic              before_r,  before_nxt;
  logic [PW-1:0]     ptr_r,     ptr_nxt;
  logic [AW-1:0]     hit_r,     hit_nxt;
  trma_pkg::id_t     succ_r,    succ_nxt;
  logic [AW-1:0]     last_r,    last_nxt;
  logic              found_r,   found_nxt;
  logic [AW-1:0]     nxt_r,     nxt_nxt;

  // response register
  trma_pkg::status_t o_status_r;
  trma_pkg::id_t     o_holder_r;
  trma_pkg::cnt_t    o_count_r;
  logic              o_changed_r;
  trma_pkg::id_t     o_slot_r;
  logic              o_emptied_r;

  logic              in_fire;
  logic              idx_ok;
  logic              join_ok;
  logic              do_join;
  logic              start_pass;
  logic              load;
  trma_pkg::id_t     join_id;
  logic [AW-1:0]     ptr_addr;
  logic [PW-1:0]     cur;
  logic [PW-1:0]     jm1;
  logic [PW-1:0]     lst;
  logic [PW-1:0]     nx;
  logic [CW-1:0]     cnt_m1;
  logic              pass_hit;

  assign in_req.ready = (state_r == S_IDLE);
  assign in_fire      = in_req.valid && in_req.ready;
  assign idx_ok       = (IW'(in_req.slot_index) < IW'(SLOTS));
  assign join_ok      = (pj_r != '0) && (count_r < SLOTS_C);
  assign join_id      = (state_r == S_IDLE) ? in_req.member_id : pj_r;
  assign ptr_addr     = (ptr_r < SLOTS_P) ? ptr_r[AW-1:0] : '0;
  assign cur          = ptr_r - PW'(1);
  assign jm1          = ptr_r - PW'(2);
  assign cnt_m1       = count_r - CW'(1);
  assign slot_q       = rd_vld_r ? rd_data_r : '0;
  assign pass_hit     = (slot_q == id_r);

  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    count_nxt   = count_r;
    owner_nxt   = owner_r;
    pj_nxt      = pj_r;
    pl_nxt      = pl_r;
    cmd_nxt     = cmd_r;
    id_nxt      = id_r;
    status_nxt  = status_r;
    changed_nxt = changed_r;
    slot_nxt    = slot_r;
    before_nxt  = before_r;
    ptr_nxt     = ptr_r;
    hit_nxt     = hit_r;
    succ_nxt    = succ_r;
    last_nxt    = last_r;
    found_nxt   = found_r;
    nxt_nxt     = nxt_r;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = '0;
    do_join     = 1'b0;
    start_pass  = 1'b0;
    load        = 1'b0;
    lst         = '0;
    nx          = '0;

    unique case (state_r)
      S_IDLE: begin
        rd_addr = idx_ok ? in_req.slot_index[AW-1:0] : '0;
        if (in_fire) begin
          cmd_nxt     = in_req.command;
          id_nxt      = in_req.member_id;
          before_nxt  = (count_r != '0);
          changed_nxt = 1'b0;
          status_nxt  = trma_pkg::ST_DONE;
          slot_nxt    = '0;
          phase_nxt   = PH_PRE;
          state_nxt   = S_FIN;
          if (in_req.command == trma_pkg::CMD_READ) begin
            if (idx_ok) state_nxt = S_RDW;
          end else if (in_req.member_id == '0) begin
            status_nxt = trma_pkg::ST_BAD_ID;
          end else if (in_req.command == trma_pkg::CMD_JOIN) begin
            if (pj_r != '0) begin
              status_nxt = trma_pkg::ST_JOIN_BUSY;
            end else begin
              pj_nxt  = in_req.member_id;
              do_join = (count_r == '0);   // empty table: insert at once
            end
          end else if (owner_r != in_req.member_id) begin
            status_nxt = trma_pkg::ST_NOT_HOLDER;
          end else begin
            state_nxt = S_DISP;
          end
        end
      end

      S_RDW: begin
        slot_nxt  = slot_q;
        state_nxt = S_FIN;
      end

      S_DISP: begin
        if (cmd_r == trma_pkg::CMD_LEAVE) begin
          unique case (phase_r)
            PH_PRE: begin
              // flush an older parked leave
              phase_nxt = PH_PARK;
              if ((pl_r != '0) && (count_r != '0)) begin
                ptr_nxt   = PW'(1);
                state_nxt = S_LV_SCAN;
              end
            end
            PH_PARK: begin
              pl_nxt = id_r;
              if (count_r == CW'(1)) begin
                do_join   = join_ok;
                phase_nxt = PH_LAST;
              end else begin
                phase_nxt = PH_PASS;
              end
            end
            PH_LAST: begin
              // last member leaving: apply its own leave now
              phase_nxt = PH_PASS;
              ptr_nxt   = PW'(1);
              state_nxt = S_LV_SCAN;
            end
            PH_PASS: start_pass = 1'b1;
            default: phase_nxt = PH_PASS;
          endcase
        end else begin
          unique case (phase_r)
            PH_PRE: begin
              do_join   = join_ok;
              phase_nxt = PH_PARK;
            end
            PH_PARK: begin
              phase_nxt = PH_PASS;
              if ((pl_r != '0) && (count_r != '0)) begin
                ptr_nxt   = PW'(1);
                state_nxt = S_LV_SCAN;
              end
            end
            PH_PASS: start_pass = 1'b1;
            default: phase_nxt = PH_PASS;
          endcase
        end
      end

      S_LV_SCAN: begin
        // slot_q holds slot ptr-1, next slot is being read
        rd_addr = ptr_addr;
        if (slot_q == pl_r) begin
          hit_nxt   = cur[AW-1:0];
          ptr_nxt   = ptr_r + PW'(1);
          state_nxt = S_LV_SHIFT;
        end else if (ptr_r >= PW'(count_r)) begin
          state_nxt = S_DISP;            // not in table: stays parked
        end else begin
          ptr_nxt = ptr_r + PW'(1);
        end
      end

      S_LV_SHIFT: begin
        rd_addr = ptr_addr;
        wr_en   = 1'b1;
        if (cur < PW'(count_r)) begin
          wr_addr = jm1[AW-1:0];
          wr_data = slot_q;
          if (ptr_r == (PW'(hit_r) + PW'(2))) succ_nxt = slot_q;
          ptr_nxt = ptr_r + PW'(1);
        end else begin
          // clear the old tail and settle the holder
          wr_addr     = cnt_m1[AW-1:0];
          wr_data     = '0;
          count_nxt   = cnt_m1;
          pl_nxt      = '0;
          changed_nxt = 1'b1;
          state_nxt   = S_DISP;
          if (pl_r == owner_r) begin
            if (cnt_m1 == '0) begin
              owner_nxt = '0;
            end else if (CW'(hit_r) < cnt_m1) begin
              owner_nxt = succ_r;
            end else begin
              state_nxt = S_LV_HEAD;     // removed entry was the tail: wrap
            end
          end
        end
      end

      S_LV_HEAD: begin
        rd_addr   = '0;
        state_nxt = S_LV_OWN;
      end

      S_LV_OWN: begin
        owner_nxt = slot_q;
        state_nxt = S_DISP;
      end

      S_PS_SCAN: begin
        rd_addr = ptr_addr;
        if (ptr_r >= PW'(count_r)) begin
          if (pass_hit || found_r) begin
            lst       = pass_hit ? cur : PW'(last_r);
            nx        = lst + PW'(1);
            nxt_nxt   = (nx >= PW'(count_r)) ? '0 : nx[AW-1:0];
            state_nxt = S_PS_RD;
          end else begin
            state_nxt = S_FIN;           // requester not listed: holder kept
          end
        end else begin
          if (pass_hit) begin
            found_nxt = 1'b1;
            last_nxt  = cur[AW-1:0];
          end
          ptr_nxt = ptr_r + PW'(1);
        end
      end

      S_PS_RD: begin
        rd_addr   = nxt_r;
        state_nxt = S_PS_GET;
      end

      S_PS_GET: begin
        owner_nxt = slot_q;
        state_nxt = S_FIN;
      end

      S_FIN: begin
        if (count_r == '0) owner_nxt = '0;
        if (!out_valid_r || out_rsp.ready) begin
          load      = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // token pass only while the requester still holds it
    if (start_pass) begin
      found_nxt = 1'b0;
      ptr_nxt   = PW'(1);
      state_nxt = ((owner_r == id_r) && (count_r != '0)) ? S_PS_SCAN : S_FIN;
    end

    // parked join goes to the first free slot (table stays compacted)
    if (do_join) begin
      wr_en       = 1'b1;
      wr_addr     = count_r[AW-1:0];
      wr_data     = join_id;
      pj_nxt      = '0;
      count_nxt   = count_r + CW'(1);
      changed_nxt = 1'b1;
      if (count_r == '0) owner_nxt = join_id;
    end

    out_valid_nxt = out_valid_r && !out_rsp.ready;
    if (load) out_valid_nxt = 1'b1;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_PRE;
      count_r     <= '0;
      owner_r     <= '0;
      pj_r        <= '0;
      pl_r        <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      owner_r     <= owner_nxt;
      pj_r        <= pj_nxt;
      pl_r        <= pl_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_en) vld_r[wr_addr] <= 1'b1;
    end
  end

  // working and response registers
  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    id_r      <= id_nxt;
    status_r  <= status_nxt;
    changed_r <= changed_nxt;
    slot_r    <= slot_nxt;
    before_r  <= before_nxt;
    ptr_r     <= ptr_nxt;
    hit_r     <= hit_nxt;
    succ_r    <= succ_nxt;
    last_r    <= last_nxt;
    found_r   <= found_nxt;
    nxt_r     <= nxt_nxt;
    if (load) begin
      o_status_r  <= status_r;
      o_holder_r  <= (count_r == '0) ? '0 : owner_r;
      o_count_r   <= OW'(count_r);
      o_changed_r <= changed_r;
      o_slot_r    <= slot_r;
      o_emptied_r <= before_r && (count_r == '0);
    end
  end

  // member table storage
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr] <= wr_data;
    rd_data_r <= mem_r[rd_addr];
    rd_vld_r  <= vld_r[rd_addr];
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.status        = o_status_r;
  assign out_rsp.holder_id     = o_holder_r;
  assign out_rsp.count_now     = o_count_r;
  assign out_rsp.list_changed  = o_changed_r;
  assign out_rsp.slot_value    = o_slot_r;
  assign out_rsp.table_emptied = o_emptied_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= SLOTS_C)
    else $error("member count beyond table size");

  a_idle_empty_no_holder: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && count_r == '0) |-> (owner_r == '0))
    else $error("token holder set with empty table");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_req.ready)
    else $error("second request taken while one is in flight");

  a_rsp_empty_holder: assert property (@(posedge clk) disable iff (!rst_n)
    (out_rsp.valid && out_rsp.count_now == '0) |-> (out_rsp.holder_id == '0))
    else $error("response reports holder with no members");

endmodule

`default_nettype wire

/* dv/token_ring_membership_arbiter_unit_tb.sv */
// Self-checking testbench for token_ring_membership_arbiter_unit.
// Depends on trma_pkg, the channel interfaces in trma_if.sv and the unit itself.
// A cycle-free predictor of the member ring produces one expected response per request.

module token_ring_membership_arbiter_unit_tb;

  localparam int SLOTS      = 8;
  localparam int TAIL_WAIT  = 4 * SLOTS + 40;
  localparam int RUN_LIMIT  = 4_000_000;        // time units

  // one expected response transfer
  typedef struct packed {
    trma_pkg::status_t status;
    trma_pkg::id_t     holder;
    trma_pkg::cnt_t    count;
    logic              changed;
    trma_pkg::id_t     slot;
    logic              emptied;
  } arb_rsp_t;

  logic clk;
  logic rst_n;

  trma_req_if in_req();
  trma_rsp_if out_rsp();

  token_ring_membership_arbiter_unit #(.SLOTS(SLOTS)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .out_rsp(out_rsp)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: the member ring as the unit should hold it.
  // ---------------------------------------------------------------------------
  trma_pkg::id_t ring_tbl [SLOTS];
  int            ring_cnt;
  trma_pkg::id_t ring_holder;
  trma_pkg::id_t parked_join;
  trma_pkg::id_t parked_leave;

  arb_rsp_t predicted_rsps [$];
  int       err_count = 0;
  bit       no_idle;     // set for stretches with back-to-back traffic on both sides
  int       rsp_stall = 0;

  // fixed id pool so that duplicate joins actually happen
  trma_pkg::id_t id_pool [12] = '{16'h0001, 16'h0002, 16'h0003, 16'h00FF, 16'h0100,
                                  16'h1234, 16'h5555, 16'hAAAA, 16'h7FFF, 16'h8000,
                                  16'hFFFE, 16'hFFFF};

  function automatic void ring_clear();
    for (int i = 0; i < SLOTS; i++) ring_tbl[i] = '0;
    ring_cnt     = 0;
    ring_holder  = '0;
    parked_join  = '0;
    parked_leave = '0;
  endfunction

  // parked join goes to the first free slot; count becomes that slot + 1
  function automatic bit ring_insert_parked();
    bit done;
    done = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!done && ring_tbl[i] == '0) begin
        ring_tbl[i] = parked_join;
        parked_join = '0;
        ring_cnt    = i + 1;
        if (ring_cnt == 1) ring_holder = ring_tbl[i];
        done = 1'b1;
      end
    end
    return done;
  endfunction

  // parked leave removes its first entry and shifts the rest down;
  // if it is not in the table it stays parked
  function automatic bit ring_remove_parked();
    int  hit;
    int  last;
    bit  stop;
    hit = SLOTS;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (ring_tbl[i] == parked_leave) hit = i;
    end
    if (hit == SLOTS) return 1'b0;
    last = hit;
    stop = 1'b0;
    for (int j = hit + 1; j < SLOTS; j++) begin
      if (!stop) begin
        if (ring_tbl[j] == '0) begin
          stop = 1'b1;
        end else begin
          ring_tbl[j-1] = ring_tbl[j];
          last++;
        end
      end
    end
    ring_tbl[last] = '0;
    if (parked_leave == ring_holder) begin
      if (last == 0)        ring_holder = '0;
      else if (hit < last)  ring_holder = ring_tbl[hit];
      else                  ring_holder = ring_tbl[0];
    end
    parked_leave = '0;
    ring_cnt     = last;
    return 1'b1;
  endfunction

  // the last slot holding the requester decides the successor
  function automatic void ring_pass_token(trma_pkg::id_t req);
    bit            found;
    trma_pkg::id_t nxt;
    int            n;
    found = 1'b0;
    nxt   = '0;
    if (ring_holder != req) return;
    for (int i = 0; i < SLOTS; i++) begin
      if (ring_tbl[i] == req) begin
        n = i + 1;
        if (n >= SLOTS)             n = 0;
        else if (ring_tbl[n] == '0) n = 0;
        nxt   = ring_tbl[n];
        found = 1'b1;
      end
    end
    if (found) ring_holder = nxt;
  endfunction

  function automatic arb_rsp_t predict_arbiter(trma_pkg::cmd_t c, trma_pkg::id_t id,
                                               trma_pkg::idx_t ix);
    arb_rsp_t r;
    int       prior;
    bit       chg;
    r     = '0;
    prior = ring_cnt;
    chg   = 1'b0;
    if (c == trma_pkg::CMD_READ) begin
      if (int'(ix) < SLOTS) r.slot = ring_tbl[int'(ix)];
    end else if (id == '0) begin
      r.status = trma_pkg::ST_BAD_ID;
    end else if (c == trma_pkg::CMD_JOIN) begin
      if (parked_join != '0) begin
        r.status = trma_pkg::ST_JOIN_BUSY;
      end else begin
        parked_join = id;
        if (ring_cnt == 0) chg = ring_insert_parked();
      end
    end else if (ring_holder != id) begin
      r.status = trma_pkg::ST_NOT_HOLDER;
    end else if (c == trma_pkg::CMD_LEAVE) begin
      // an older parked leave goes first, then this one is parked
      if (parked_leave != '0) chg |= ring_remove_parked();
      parked_leave = id;
      if (ring_cnt == 1) begin
        if (parked_join != '0) chg |= ring_insert_parked();
        chg |= ring_remove_parked();
      end
      ring_pass_token(id);
    end else begin
      if (parked_join != '0)  chg |= ring_insert_parked();
      if (parked_leave != '0) chg |= ring_remove_parked();
      ring_pass_token(id);
    end
    if (ring_cnt == 0) ring_holder = '0;
    r.holder  = ring_holder;
    r.count   = trma_pkg::cnt_t'(ring_cnt);
    r.changed = chg;
    r.emptied = (prior != 0 && ring_cnt == 0);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, gap length, request driver
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  // Valid is not lowered on acceptance: a back-to-back request keeps it high,
  // a gap lowers it at the start of the next call.
  task automatic send_req(trma_pkg::cmd_t c, trma_pkg::id_t id, trma_pkg::idx_t ix);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.valid      <= 1'b1;
    in_req.command    <= c;
    in_req.member_id  <= id;
    in_req.slot_index <= ix;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    predicted_rsps.push_back(predict_arbiter(c, id, ix));
  endtask

  // ---------------------------------------------------------------------------
  // Response side: random stalls on ready, check every transfer in order
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    arb_rsp_t got;
    arb_rsp_t want;
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      got = '{out_rsp.status, out_rsp.holder_id, out_rsp.count_now, out_rsp.list_changed,
              out_rsp.slot_value, out_rsp.table_emptied};
      if (predicted_rsps.size() == 0) begin
        if (err_count < 10) $display("%0t: response with none expected: %p", $realtime, got);
        err_count++;
      end else begin
        want = predicted_rsps.pop_front();
        if (got.status !== want.status || got.holder !== want.holder ||
            got.count !== want.count || got.changed !== want.changed ||
            got.slot !== want.slot || got.emptied !== want.emptied) begin
          if (err_count < 10)
            $display("%0t: mismatch st %0d/%0d holder %h/%h cnt %0d/%0d", $realtime,
                     want.status, got.status, want.holder, got.holder,
                     want.count, got.count,
                     " chg %b/%b slot %h/%h emp %b/%b (exp/act)",
                     want.changed, got.changed, want.slot, got.slot,
                     want.emptied, got.emptied);
          err_count++;
        end
      end
    end
    if (rsp_stall > 0) begin
      out_rsp.ready <= 1'b0;
      rsp_stall--;
    end else begin
      out_rsp.ready <= 1'b1;
      rsp_stall = pick_gap();
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // zero id on every command that takes one, reads of an empty table
  task automatic test_reject_paths();
    send_req(trma_pkg::CMD_JOIN, '0, '0);
    send_req(trma_pkg::CMD_LEAVE, '0, '0);
    send_req(trma_pkg::CMD_SERVICE, '0, '0);
    send_req(trma_pkg::CMD_READ, 16'hFFFF, '0);
    send_req(trma_pkg::CMD_READ, '0, trma_pkg::idx_t'(63));
  endtask

  // join into empty table inserts at once, busy join, leave from non-holder,
  // service applies the parked join and passes the token
  task automatic test_first_members();
    send_req(trma_pkg::CMD_JOIN, 16'hFFFF, '0);
    send_req(trma_pkg::CMD_READ, '0, '0);
    send_req(trma_pkg::CMD_JOIN, 16'h0001, trma_pkg::idx_t'(63));
    send_req(trma_pkg::CMD_JOIN, 16'h8000, '0);
    send_req(trma_pkg::CMD_LEAVE, 16'h0001, '0);
    send_req(trma_pkg::CMD_SERVICE, ring_holder, '0);
    send_req(trma_pkg::CMD_READ, '0, trma_pkg::idx_t'(1));
  endtask

  // duplicate join, parked leave with two members, reads past the table end
  task automatic test_leave_paths();
    send_req(trma_pkg::CMD_JOIN, ring_holder, '0);
    send_req(trma_pkg::CMD_LEAVE, ring_holder, '0);
    send_req(trma_pkg::CMD_SERVICE, ring_holder, '0);
    send_req(trma_pkg::CMD_READ, '0, trma_pkg::idx_t'(SLOTS));
    send_req(trma_pkg::CMD_JOIN, 16'hAAAA, '0);
    send_req(trma_pkg::CMD_JOIN, 16'h5555, '0);
    send_req(trma_pkg::CMD_SERVICE, ring_holder, '0);
  endtask

  // holder leaves and services until the table is empty (last member leaving)
  task automatic test_drain();
    for (int k = 0; k < 4 * SLOTS; k++) begin
      if (ring_cnt > 0 && ring_holder != '0) begin
        send_req(trma_pkg::CMD_LEAVE, ring_holder, trma_pkg::idx_t'($urandom_range(0, 63)));
        send_req(trma_pkg::CMD_SERVICE, ring_holder,
                 trma_pkg::idx_t'($urandom_range(0, 63)));
      end
    end
    send_req(trma_pkg::CMD_READ, trma_pkg::id_t'($urandom), '0);
  endtask

  // Well-formed traffic: leave and service come from the current holder,
  // joins use fresh or pooled ids. Noise items carry random everything.
  task automatic run_traffic(int n_items, int w_join, int w_leave, int w_service,
                             int w_read, int w_noise);
    int             total;
    int             r;
    trma_pkg::id_t  id;
    trma_pkg::idx_t ix;
    total = w_join + w_leave + w_service + w_read + w_noise;
    for (int k = 0; k < n_items; k++) begin
      r  = $urandom_range(0, total - 1);
      ix = trma_pkg::idx_t'($urandom_range(0, 63));
      if (r < w_join) begin
        id = ($urandom_range(0, 2) == 0) ? id_pool[$urandom_range(0, 11)] :
                                           trma_pkg::id_t'($urandom);
        if (id == '0) id = 16'h0001;
        send_req(trma_pkg::CMD_JOIN, id, ix);
      end else if (r < w_join + w_leave) begin
        id = (ring_holder != '0) ? ring_holder : trma_pkg::id_t'($urandom);
        send_req(trma_pkg::CMD_LEAVE, id, ix);
      end else if (r < w_join + w_leave + w_service) begin
        id = (ring_holder != '0) ? ring_holder : trma_pkg::id_t'($urandom);
        send_req(trma_pkg::CMD_SERVICE, id, ix);
      end else if (r < w_join + w_leave + w_service + w_read) begin
        if ($urandom_range(0, 1) == 0) ix = trma_pkg::idx_t'($urandom_range(0, SLOTS));
        send_req(trma_pkg::CMD_READ, trma_pkg::id_t'($urandom), ix);
      end else begin
        id = ($urandom_range(0, 3) == 0) ? '0 : trma_pkg::id_t'($urandom);
        if ($urandom_range(0, 3) == 0) id = id_pool[$urandom_range(0, 11)];
        send_req(trma_pkg::cmd_t'($urandom_range(0, 3)), id, ix);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n              <= 1'b0;
    in_req.valid       <= 1'b0;
    in_req.command     <= trma_pkg::CMD_READ;
    in_req.member_id   <= '0;
    in_req.slot_index  <= '0;
    no_idle   = 1'b0;
    ring_clear();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_reject_paths();
    test_first_members();
    test_leave_paths();
    test_drain();

    run_traffic(300, 40, 5, 30, 15, 10);     // grow until the table is full
    run_traffic(500, 25, 20, 30, 15, 10);    // steady churn
    no_idle = 1'b1;
    run_traffic(300, 25, 20, 30, 15, 10);    // back-to-back, no stalls
    no_idle = 1'b0;
    run_traffic(300, 10, 45, 30, 10, 5);     // shrink, tables empty often
    run_traffic(250, 20, 20, 20, 10, 30);    // noise heavy
    test_drain();
    in_req.valid <= 1'b0;

    while (predicted_rsps.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (err_count == 0 && predicted_rsps.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #RUN_LIMIT;
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* files.f */
rtl/trma_pkg.sv
rtl/trma_if.sv
rtl/token_ring_membership_arbiter_unit.sv
dv/token_ring_membership_arbiter_unit_tb.sv
